FILE: rtl/integer_field_formatter_unit_macros.svh
// ---------------------------------------------------------------------------
// Integer field formatter assertion macros
// Concurrent check helpers, clocked on clk_i and held off during reset.
// ---------------------------------------------------------------------------
`ifndef INTEGER_FIELD_FORMATTER_UNIT_MACROS_SVH
`define INTEGER_FIELD_FORMATTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset
`define IFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds at a clock edge out of reset
`define IFF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define IFF_ASSERT(lbl, prop, msg)

`define IFF_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: rtl/iff_pkg.sv
// ---------------------------------------------------------------------------
// Integer field formatter package
// Shared defaults, character codes, digit lookup and control structs.
// ---------------------------------------------------------------------------
package iff_pkg;

  // Default configuration
  localparam int unsigned FIELD_MAX_DEF  = 62;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic prep;
    logic layout;
    logic emit;
  } iff_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_hex;
    logic conv_last;
    logic emit_last;
    logic empty;
  } iff_sts_t;

  // Map one digit to its lowercase ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'ha: c = 8'h61;
      4'hb: c = 8'h62;
      4'hc: c = 8'h63;
      4'hd: c = 8'h64;
      4'he: c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/iff_controller.sv
// ---------------------------------------------------------------------------
// Integer field formatter controller
// Sequences load, digit conversion, layout and character output.
// ---------------------------------------------------------------------------
module iff_controller
  import iff_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  iff_sts_t sts_i,
  output iff_cmd_t cmd_o,
  output logic     busy_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CONV   = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_LAYOUT = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        if (sts_i.is_hex) begin
          state_d = S_PREP;
        end else begin
          cmd_o.conv_step = 1'b1;
          if (sts_i.conv_last) state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_LAYOUT;
      end
      S_LAYOUT: begin
        cmd_o.layout = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.empty || sts_i.emit_last) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: rtl/iff_datapath.sv
// ---------------------------------------------------------------------------
// Integer field formatter datapath
// Request registers, binary to decimal shifter, field layout and output.
// ---------------------------------------------------------------------------
module iff_datapath
  import iff_pkg::*;
#(
  parameter int unsigned FIELD_MAX  = FIELD_MAX_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  iff_cmd_t    cmd_i,
  output iff_sts_t    sts_o,
  input  logic        req_type_i,
  input  logic [31:0] value_i,
  input  logic        short_length_i,
  input  logic [5:0]  field_width_i,
  input  logic        has_precision_i,
  input  logic [5:0]  min_digits_i,
  input  logic        flag_left_i,
  input  logic        flag_plus_i,
  input  logic        flag_space_i,
  input  logic        flag_zero_i,
  input  logic        flag_alt_i,
  output logic [7:0]  out_char_o,
  output logic        last_char_o,
  output logic        char_valid_o
);

  // Decimal digits of the largest operand: floor(bits * log10(2)) + 1
  localparam int unsigned NDIG = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned BCDW = 4 * NDIG;
  localparam int unsigned LW   = $clog2(FIELD_MAX + 3);
  localparam int unsigned DIW  = $clog2(NDIG);
  localparam int unsigned CW   = $clog2(VALUE_BITS);

  // Request registers
  logic                  hex_q, neg_q, zmag_q, left_q, plus_q, space_q, zero_q, alt_q, hasp_q;
  logic [5:0]            width_q, prec_q;
  logic [VALUE_BITS-1:0] sh_q;
  logic [BCDW-1:0]       bcd_q;
  logic [CW-1:0]         cnt_q;
  logic [LW-1:0]         nd_q;
  logic [1:0]            np_q;
  logic [LW-1:0]         b1_q, b2_q, b3_q, b4_q, bend_q, pos_q;
  logic [DIW-1:0]        dig_idx_q;
  logic [7:0]            char_q;
  logic                  last_q, valid_q;

  // Narrow and take the magnitude of the incoming operand; saturate width and precision
  logic                  use_short, in_neg;
  logic [15:0]           v_short;
  logic [VALUE_BITS-1:0] v_full, mag;
  logic [5:0]            width_sat, prec_sat;

  always_comb begin
    v_short   = value_i[15:0];
    v_full    = value_i[VALUE_BITS-1:0];
    use_short = !req_type_i && short_length_i;
    in_neg    = !req_type_i && (use_short ? v_short[15] : v_full[VALUE_BITS-1]);
    if (use_short) begin
      mag = in_neg ? VALUE_BITS'(16'(~v_short + 16'd1)) : VALUE_BITS'(v_short);
    end else begin
      mag = in_neg ? (~v_full + VALUE_BITS'(1)) : v_full;
    end
    width_sat   = (field_width_i > 6'(FIELD_MAX)) ? 6'(FIELD_MAX) : field_width_i;
    prec_sat    = (min_digits_i > 6'(FIELD_MAX)) ? 6'(FIELD_MAX) : min_digits_i;
  end

  // One shift-and-correct step of the binary to decimal conversion
  logic [BCDW-1:0] bcd_adj, bcd_step;

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3 : bcd_q[4*k +: 4];
    end
    bcd_step = {bcd_adj[BCDW-2:0], sh_q[VALUE_BITS-1]};
  end

  // Count digits and prefix characters
  logic [LW-1:0] top, nd_d;
  logic [1:0]    np_d;

  always_comb begin
    top = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_q[4*k +: 4] != 4'd0) top = LW'(k + 1);
    end
    if (hasp_q && (prec_q == 6'd0) && zmag_q) begin
      nd_d = '0;
    end else begin
      nd_d = (top == '0) ? LW'(1) : top;
    end
    if (hex_q) begin
      np_d = (alt_q && !zmag_q) ? 2'd2 : 2'd0;
    end else begin
      np_d = (neg_q || plus_q || space_q) ? 2'd1 : 2'd0;
    end
  end

  // Lay out the field as segment boundaries
  logic [LW-1:0] prec_l, width_l, pz, total, pad, lead, zeros, trail;
  logic [LW-1:0] b1_d, b2_d, b3_d, b4_d, bend_d;
  logic          zf;

  always_comb begin
    prec_l  = LW'(prec_q);
    width_l = LW'(width_q);
    pz      = (prec_l > nd_q) ? prec_l - nd_q : '0;
    total   = LW'(np_q) + pz + nd_q;
    pad     = (width_l > total) ? width_l - total : '0;
    zf      = zero_q && !hasp_q && !left_q;
    lead    = (!left_q && !zf) ? pad : '0;
    zeros   = pz + (zf ? pad : '0);
    trail   = left_q ? pad : '0;
    b1_d    = lead;
    b2_d    = b1_d + LW'(np_q);
    b3_d    = b2_d + zeros;
    b4_d    = b3_d + nd_q;
    bend_d  = b4_d + trail;
  end

  // Pick the character at the current position
  logic [7:0] ch, sign_ch;
  logic [3:0] digit;
  logic       in_digits, last_d, empty;

  always_comb begin
    digit     = bcd_q[{dig_idx_q, 2'b00} +: 4];
    in_digits = (pos_q >= b3_q) && (pos_q < b4_q);
    if (neg_q) begin
      sign_ch = CH_MINUS;
    end else if (plus_q) begin
      sign_ch = CH_PLUS;
    end else begin
      sign_ch = CH_SPACE;
    end
    if (pos_q < b1_q) begin
      ch = CH_SPACE;
    end else if (pos_q < b2_q) begin
      ch = hex_q ? ((pos_q == b1_q) ? CH_ZERO : CH_X) : sign_ch;
    end else if (pos_q < b3_q) begin
      ch = CH_ZERO;
    end else if (in_digits) begin
      ch = digit_char(digit);
    end else begin
      ch = CH_SPACE;
    end
    last_d = (pos_q + LW'(1) == bend_q);
    empty  = (bend_q == '0);
  end

  assign sts_o.is_hex    = hex_q;
  assign sts_o.conv_last = (cnt_q == '0);
  assign sts_o.emit_last = last_d;
  assign sts_o.empty     = empty;

  // Advance the datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hex_q   <= req_type_i;
      neg_q   <= in_neg;
      zmag_q  <= (mag == '0);
      left_q  <= flag_left_i;
      plus_q  <= flag_plus_i;
      space_q <= flag_space_i;
      zero_q  <= flag_zero_i;
      alt_q   <= flag_alt_i;
      hasp_q  <= has_precision_i;
      width_q <= width_sat;
      prec_q  <= has_precision_i ? prec_sat : 6'd0;
      sh_q    <= mag;
      bcd_q   <= req_type_i ? BCDW'(mag) : '0;
      cnt_q   <= CW'(VALUE_BITS - 1);
    end
    if (cmd_i.conv_step) begin
      bcd_q <= bcd_step;
      sh_q  <= sh_q << 1;
      cnt_q <= cnt_q - CW'(1);
    end
    if (cmd_i.prep) begin
      nd_q <= nd_d;
      np_q <= np_d;
    end
    if (cmd_i.layout) begin
      b1_q      <= b1_d;
      b2_q      <= b2_d;
      b3_q      <= b3_d;
      b4_q      <= b4_d;
      bend_q    <= bend_d;
      pos_q     <= '0;
      dig_idx_q <= DIW'(nd_q - LW'(1));
    end
    if (cmd_i.emit) begin
      pos_q  <= pos_q + LW'(1);
      char_q <= ch;
      last_q <= last_d;
      if (in_digits) dig_idx_q <= dig_idx_q - DIW'(1);
    end
  end

  // Drive the output word strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit && !empty;
    end
  end

  assign out_char_o   = char_q;
  assign last_char_o  = last_q;
  assign char_valid_o = valid_q;

endmodule

FILE: rtl/integer_field_formatter_unit.sv
// ---------------------------------------------------------------------------
// Integer field formatter unit
// Formats one %d, %hd or %x request into a field, one character per word.
// ---------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. The field then
// leaves one character per cycle on out_char_o, marked by char_valid_o, with
// last_char_o on the final character; the receiver cannot stall, so every
// strobed word must be taken in its cycle. An empty field gives no words.
// A decimal request passes through the bit-serial binary to decimal shifter,
// one operand bit per cycle; a hex request skips it. A new request is taken
// only once every character of the previous field has been emitted.
// ---------------------------------------------------------------------------
`include "integer_field_formatter_unit_macros.svh"

module integer_field_formatter_unit
  import iff_pkg::*;
#(
  parameter int unsigned FIELD_MAX  = FIELD_MAX_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [31:0] value_i,
  input  logic        short_length_i,
  input  logic [5:0]  field_width_i,
  input  logic        has_precision_i,
  input  logic [5:0]  min_digits_i,
  input  logic        flag_left_i,
  input  logic        flag_plus_i,
  input  logic        flag_space_i,
  input  logic        flag_zero_i,
  input  logic        flag_alt_i,
  output logic [7:0]  out_char_o,
  output logic        last_char_o,
  output logic        char_valid_o
);

  iff_cmd_t cmd;
  iff_sts_t sts;

  // Sequence the request
  iff_controller u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Convert and emit the field
  iff_datapath #(
    .FIELD_MAX  (FIELD_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .short_length_i  (short_length_i),
    .field_width_i   (field_width_i),
    .has_precision_i (has_precision_i),
    .min_digits_i    (min_digits_i),
    .flag_left_i     (flag_left_i),
    .flag_plus_i     (flag_plus_i),
    .flag_space_i    (flag_space_i),
    .flag_zero_i     (flag_zero_i),
    .flag_alt_i      (flag_alt_i),
    .out_char_o      (out_char_o),
    .last_char_o     (last_char_o),
    .char_valid_o    (char_valid_o)
  );

  // Check sequencing across the controller and the output register
  `IFF_ASSERT(a_accept_sets_busy, start_i && !busy_o |=> busy_o, "request accepted but not busy")
  `IFF_ASSERT(a_word_after_busy, char_valid_o |-> $past(busy_o), "word without a busy cycle")
  `IFF_ASSERT(a_gap_after_last, char_valid_o && last_char_o |=> !char_valid_o, "word after last")
  `IFF_ASSERT(a_idle_no_word, !busy_o |=> !char_valid_o, "word two cycles into idle")
  `IFF_ASSERT_NEVER(a_no_accept_mid_field, start_i && !busy_o && char_valid_o && !last_char_o, "accept mid field")

endmodule

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Integer field formatter testbench
// Sends %d, %hd and %x requests with hand-picked and random flag mixes and checks each
// character word against a field built independently inside the bench.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iff_pkg::*;

  localparam int unsigned FIELD_LIMIT  = FIELD_MAX_DEF;
  localparam int unsigned RANDOM_ITEMS = 74;
  localparam int unsigned BURST_ITEMS  = 6;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [7:0]  CH_A_LOWER   = 8'h61;

  // Flag masks: left, plus, space, zero, alternate form
  localparam bit [4:0] FL_NONE  = 5'b00000;
  localparam bit [4:0] FL_LEFT  = 5'b10000;
  localparam bit [4:0] FL_PLUS  = 5'b01000;
  localparam bit [4:0] FL_SPACE = 5'b00100;
  localparam bit [4:0] FL_ZERO  = 5'b00010;
  localparam bit [4:0] FL_ALT   = 5'b00001;

  typedef enum logic {
    CONV_DEC = 1'b0,
    CONV_HEX = 1'b1
  } conv_kind_e;

  typedef struct packed {
    conv_kind_e  conv;
    logic [31:0] operand;
    logic        narrow;
    logic [5:0]  width;
    logic        prec_given;
    logic [5:0]  prec;
    logic        left;
    logic        plus;
    logic        space;
    logic        zero;
    logic        alt;
  } format_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        req_type_i;
  logic [31:0] value_i;
  logic        short_length_i;
  logic [5:0]  field_width_i;
  logic        has_precision_i;
  logic [5:0]  min_digits_i;
  logic        flag_left_i;
  logic        flag_plus_i;
  logic        flag_space_i;
  logic        flag_zero_i;
  logic        flag_alt_i;
  logic [7:0]  out_char_o;
  logic        last_char_o;
  logic        char_valid_o;

  field_char_t pending_chars[$];
  int unsigned failure_count = 0;
  int unsigned cycle_count = 0;

  integer_field_formatter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .short_length_i (short_length_i),
    .field_width_i  (field_width_i),
    .has_precision_i(has_precision_i),
    .min_digits_i   (min_digits_i),
    .flag_left_i    (flag_left_i),
    .flag_plus_i    (flag_plus_i),
    .flag_space_i   (flag_space_i),
    .flag_zero_i    (flag_zero_i),
    .flag_alt_i     (flag_alt_i),
    .out_char_o     (out_char_o),
    .last_char_o    (last_char_o),
    .char_valid_o   (char_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void record_failure(input string msg);
    failure_count++;
    if (failure_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Build the expected field of one request and queue its characters
  function automatic void format_field(input format_req_t r);
    logic [31:0] operand;
    logic [31:0] mag;
    logic        neg;
    logic [3:0]  dig;
    logic [7:0]  digits [0:15];
    logic [7:0]  prefix [0:1];
    int unsigned width, prec, nd, np, pz, total, pad, first;
    bit          zero_fill;
    field_char_t tail;
    width = (r.width > FIELD_LIMIT) ? FIELD_LIMIT : r.width;
    prec  = !r.prec_given ? 0 : ((r.prec > FIELD_LIMIT) ? FIELD_LIMIT : r.prec);
    neg   = 1'b0;
    nd    = 0;
    np    = 0;
    first = pending_chars.size();

    // Take the operand at its conversion width
    if (r.conv == CONV_HEX) begin
      operand = r.operand;
    end else if (r.narrow) begin
      operand = {16'h0000, r.operand[15:0]};
      neg     = operand[15];
    end else begin
      operand = r.operand;
      neg     = operand[31];
    end
    mag = operand;
    if (neg) mag = (~operand + 32'd1) & (r.narrow ? 32'h0000_ffff : 32'hffff_ffff);

    // Extract digits, least significant first; none for zero at zero precision
    if (!(r.prec_given && prec == 0 && mag == 0)) begin
      do begin
        if (r.conv == CONV_HEX) begin
          dig = mag[3:0];
          mag = mag >> 4;
        end else begin
          dig = 4'(mag % 10);
          mag = mag / 10;
        end
        digits[nd] = (dig < 4'd10) ? CH_ZERO + 8'(dig) : CH_A_LOWER + 8'(dig) - 8'd10;
        nd++;
      end while (mag != 0);
    end

    // Sign for decimal, 0x for nonzero hex under the alternate form
    if (r.conv == CONV_HEX) begin
      if (r.alt && operand != 0) begin
        prefix[0] = CH_ZERO;
        prefix[1] = CH_X;
        np = 2;
      end
    end else if (neg) begin
      prefix[0] = CH_MINUS;
      np = 1;
    end else if (r.plus) begin
      prefix[0] = CH_PLUS;
      np = 1;
    end else if (r.space) begin
      prefix[0] = CH_SPACE;
      np = 1;
    end

    pz        = (r.prec_given && prec > nd) ? prec - nd : 0;
    total     = np + pz + nd;
    pad       = (width > total) ? width - total : 0;
    zero_fill = r.zero && !r.prec_given && !r.left;

    // Lay out: leading spaces, prefix, zero fill, precision zeros, digits, trailing spaces
    if (!r.left && !zero_fill)
      for (int i = 0; i < pad; i++) pending_chars.push_back('{ch: CH_SPACE, last: 1'b0});
    for (int i = 0; i < np; i++) pending_chars.push_back('{ch: prefix[i], last: 1'b0});
    if (zero_fill)
      for (int i = 0; i < pad; i++) pending_chars.push_back('{ch: CH_ZERO, last: 1'b0});
    for (int i = 0; i < pz; i++) pending_chars.push_back('{ch: CH_ZERO, last: 1'b0});
    for (int i = nd; i > 0; i--) pending_chars.push_back('{ch: digits[i-1], last: 1'b0});
    if (r.left)
      for (int i = 0; i < pad; i++) pending_chars.push_back('{ch: CH_SPACE, last: 1'b0});

    // Mark the final character, if the field has any
    if (pending_chars.size() > first) begin
      tail = pending_chars.pop_back();
      tail.last = 1'b1;
      pending_chars.push_back(tail);
    end
  endfunction

  function automatic format_req_t mk_req(input conv_kind_e conv, input logic [31:0] operand,
                                         input logic narrow, input logic [5:0] width,
                                         input logic prec_given, input logic [5:0] prec,
                                         input bit [4:0] flags);
    format_req_t r;
    r.conv       = conv;
    r.operand    = operand;
    r.narrow     = narrow;
    r.width      = width;
    r.prec_given = prec_given;
    r.prec       = prec;
    {r.left, r.plus, r.space, r.zero, r.alt} = flags;
    return r;
  endfunction

  // Random request: mostly small sizes, with operand extremes mixed in
  function automatic format_req_t rand_request();
    format_req_t r;
    r.conv = conv_kind_e'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: r.operand = 32'h0000_0000;
      1: r.operand = 32'h8000_0000;
      2: r.operand = 32'h7fff_ffff;
      3: r.operand = 32'hffff_ffff;
      4: r.operand = $urandom_range(0, 20);
      5: r.operand = {16'($urandom), 16'h8000};
      6: r.operand = -32'($urandom_range(1, 40000));
      default: r.operand = $urandom;
    endcase
    r.narrow     = 1'($urandom_range(0, 1));
    r.width      = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 14));
    r.prec_given = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0, 1:    r.prec = 6'd0;
      2:       r.prec = 6'($urandom_range(0, 63));
      default: r.prec = 6'($urandom_range(1, 12));
    endcase
    {r.left, r.plus, r.space, r.zero, r.alt} = 5'($urandom);
    return r;
  endfunction

  // Hold one word on the inputs until the block takes it; leave start raised
  task automatic send_request(input format_req_t r);
    start_i         <= 1'b1;
    req_type_i      <= r.conv;
    value_i         <= r.operand;
    short_length_i  <= r.narrow;
    field_width_i   <= r.width;
    has_precision_i <= r.prec_given;
    min_digits_i    <= r.prec;
    flag_left_i     <= r.left;
    flag_plus_i     <= r.plus;
    flag_space_i    <= r.space;
    flag_zero_i     <= r.zero;
    flag_alt_i      <= r.alt;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    format_field(r);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drop start and hold until every queued character has come out
  task automatic wait_for_drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  // Check each strobed word against the oldest expected character
  always @(posedge clk_i) begin : check_words
    field_char_t want;
    if (rst_ni && char_valid_o === 1'b1) begin
      if (pending_chars.size() == 0) begin
        record_failure($sformatf("unexpected word: char 0x%02h last %0b",
                                 out_char_o, last_char_o));
      end else begin
        want = pending_chars.pop_front();
        if (out_char_o !== want.ch || last_char_o !== want.last)
          record_failure($sformatf("char 0x%02h last %0b, expected char 0x%02h last %0b",
                                   out_char_o, last_char_o, want.ch, want.last));
      end
    end
  end

  task automatic test_decimal_corners();
    // Zero, both 32-bit extremes, minus one
    send_request(mk_req(CONV_DEC, 32'h0000_0000, 1'b0, 6'd0, 1'b0, 6'd0, FL_NONE));
    send_request(mk_req(CONV_DEC, 32'h8000_0000, 1'b0, 6'd0, 1'b0, 6'd0, FL_NONE));
    send_request(mk_req(CONV_DEC, 32'h7fff_ffff, 1'b0, 6'd0, 1'b0, 6'd0, FL_PLUS));
    send_request(mk_req(CONV_DEC, 32'hffff_ffff, 1'b0, 6'd0, 1'b0, 6'd0, FL_SPACE));
    // Plus beats space; zero fill after the sign or space
    send_request(mk_req(CONV_DEC, 32'd42, 1'b0, 6'd0, 1'b0, 6'd0, FL_PLUS | FL_SPACE));
    send_request(mk_req(CONV_DEC, 32'd7, 1'b0, 6'd5, 1'b0, 6'd0, FL_SPACE | FL_ZERO));
    send_request(mk_req(CONV_DEC, -32'd5, 1'b0, 6'd6, 1'b0, 6'd0, FL_ZERO));
    // Zero fill ignored under left-align and under a precision
    send_request(mk_req(CONV_DEC, 32'd5, 1'b0, 6'd4, 1'b0, 6'd0, FL_ZERO | FL_LEFT));
    send_request(mk_req(CONV_DEC, 32'd5, 1'b0, 6'd6, 1'b1, 6'd3, FL_ZERO));
    // Zero at zero precision: empty field, then sign and padding only
    send_request(mk_req(CONV_DEC, 32'd0, 1'b0, 6'd0, 1'b1, 6'd0, FL_NONE));
    send_request(mk_req(CONV_DEC, 32'd0, 1'b0, 6'd3, 1'b1, 6'd0, FL_PLUS));
    // Short length extremes; alternate form ignored on decimal
    send_request(mk_req(CONV_DEC, 32'h1234_8000, 1'b1, 6'd0, 1'b0, 6'd0, FL_NONE));
    send_request(mk_req(CONV_DEC, 32'hffff_7fff, 1'b1, 6'd0, 1'b0, 6'd0, FL_PLUS));
    send_request(mk_req(CONV_DEC, 32'd255, 1'b0, 6'd0, 1'b0, 6'd0, FL_ALT));
    // Width and precision above the limit saturate
    send_request(mk_req(CONV_DEC, 32'hffff_ffff, 1'b0, 6'd63, 1'b0, 6'd0, FL_LEFT));
    send_request(mk_req(CONV_DEC, 32'd1, 1'b0, 6'd0, 1'b1, 6'd63, FL_PLUS));
  endtask

  task automatic test_hex_corners();
    send_request(mk_req(CONV_HEX, 32'hffff_ffff, 1'b0, 6'd0, 1'b0, 6'd0, FL_ALT));
    // No prefix on a zero value
    send_request(mk_req(CONV_HEX, 32'h0000_0000, 1'b0, 6'd0, 1'b0, 6'd0, FL_ALT));
    // Zero fill goes after 0x
    send_request(mk_req(CONV_HEX, 32'h0000_0abc, 1'b0, 6'd10, 1'b0, 6'd0, FL_ALT | FL_ZERO));
    // Plus, space and short length ignored on hex
    send_request(mk_req(CONV_HEX, 32'hdead_001f, 1'b1, 6'd12, 1'b0, 6'd0, FL_PLUS | FL_SPACE));
    send_request(mk_req(CONV_HEX, 32'h0000_0000, 1'b0, 6'd5, 1'b1, 6'd0, FL_NONE));
    // Longest field: prefix and a saturated precision
    send_request(mk_req(CONV_HEX, 32'h0000_0005, 1'b0, 6'd63, 1'b1, 6'd63, FL_ALT | FL_LEFT));
    send_request(mk_req(CONV_HEX, 32'h0000_0010, 1'b0, 6'd6, 1'b0, 6'd0, FL_LEFT));
    send_request(mk_req(CONV_HEX, 32'h89ab_cdef, 1'b0, 6'd12, 1'b1, 6'd4, FL_ZERO));
  endtask

  // Random words in bursts of random length, with random gaps between them
  task automatic test_random_bursts();
    int unsigned burst;
    burst = 0;
    repeat (RANDOM_ITEMS) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
        if ($urandom_range(0, 3) != 0)
          idle_sender(($urandom_range(0, 5) == 0) ? $urandom_range(41, 150)
                                                  : $urandom_range(1, 40));
      end
      send_request(rand_request());
      burst--;
    end
  endtask

  // Let the block empty completely, then restart back to back
  task automatic test_drain_pause();
    repeat (BURST_ITEMS) send_request(rand_request());
    wait_for_drain();
    repeat (BURST_ITEMS) send_request(rand_request());
  endtask

  initial begin
    rst_ni          <= 1'b0;
    start_i         <= 1'b0;
    req_type_i      <= CONV_DEC;
    value_i         <= 32'h0;
    short_length_i  <= 1'b0;
    field_width_i   <= 6'd0;
    has_precision_i <= 1'b0;
    min_digits_i    <= 6'd0;
    flag_left_i     <= 1'b0;
    flag_plus_i     <= 1'b0;
    flag_space_i    <= 1'b0;
    flag_zero_i     <= 1'b0;
    flag_alt_i      <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_decimal_corners();
    test_hex_corners();
    test_drain_pause();
    test_random_bursts();

    // Drain, then give a stray word time to show up
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (failure_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: integer_field_formatter_unit.f
+incdir+rtl
rtl/iff_pkg.sv
rtl/iff_controller.sv
rtl/iff_datapath.sv
rtl/integer_field_formatter_unit.sv
tb/sv/tb_top.sv
